### rtl/core/perfect_cube_test_defines.svh
// assertion macros for the perfect cube test block
`ifndef PERFECT_CUBE_TEST_DEFINES_SVH
`define PERFECT_CUBE_TEST_DEFINES_SVH

`ifndef SYNTHESIS

`define PCT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PCT_ASSERT_SAME(label, ante, cons, msg)

`define PCT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/core/pct_pkg.sv
// shared widths and stage word type for the perfect cube test
package pct_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int VALUE_W    = 32;
   localparam int EXT_W      = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int STEPS      = (DATA_WIDTH - 1) / 3 + 1;
   localparam int ROOT_W     = (DATA_WIDTH + 2) / 3;
   localparam int SQ_W       = 2 * ROOT_W;
   localparam int B_W        = 2 * ROOT_W + 4;
   localparam int CMP_W      = (DATA_WIDTH > B_W) ? DATA_WIDTH : B_W;
   localparam int SHIFT_W    = $clog2(DATA_WIDTH);

   typedef struct packed {
      logic                  neg;
      logic [DATA_WIDTH-1:0] rem;
      logic [ROOT_W-1:0]     root;
      logic [SQ_W-1:0]       root_sq;
   } stage_type;

endpackage

### rtl/core/pct_req_if.sv
// request channel carrying the value to test
interface pct_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

### rtl/core/pct_rsp_if.sv
// response channel carrying the cube verdict
interface pct_rsp_if;
   logic valid;
   logic ready;
   logic is_cube;
   logic negative_error;

   modport source (output valid, output is_cube, output negative_error, input ready);
   modport sink   (input valid, input is_cube, input negative_error, output ready);
endinterface

### rtl/core/pct_cell.sv
// one cube root digit cell with its own valid and back pressure
module pct_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pct_pkg::SHIFT_W-1:0]   shift,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  pct_pkg::stage_type            in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output pct_pkg::stage_type            out_data
);

   logic                       valid_ff;
   logic                       valid_in;
   pct_pkg::stage_type         data_ff;
   pct_pkg::stage_type         data_in;
   logic [pct_pkg::ROOT_W-1:0] root_dbl;
   logic [pct_pkg::B_W-1:0]    delta;
   logic [pct_pkg::CMP_W-1:0]  rem_top;
   logic [pct_pkg::CMP_W-1:0]  delta_sh;
   logic                       take;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // 12*r^2 + 6*r + 1 gives (2r+1)^3 - (2r)^3
   always_comb begin
      root_dbl = pct_pkg::ROOT_W'({in_data.root, 1'b0});
      delta    = (pct_pkg::B_W'(in_data.root_sq) << 3) + (pct_pkg::B_W'(in_data.root_sq) << 2)
               + (pct_pkg::B_W'(in_data.root) << 2) + (pct_pkg::B_W'(in_data.root) << 1)
               + pct_pkg::B_W'(1);
      rem_top  = pct_pkg::CMP_W'(in_data.rem) >> shift;
      delta_sh = pct_pkg::CMP_W'(delta) << shift;
      take     = !in_data.neg && (rem_top >= pct_pkg::CMP_W'(delta));

      data_in.neg = in_data.neg;
      if (take) begin
         data_in.rem     = in_data.rem - delta_sh[pct_pkg::DATA_WIDTH-1:0];
         data_in.root    = root_dbl | pct_pkg::ROOT_W'(1);
         data_in.root_sq = (in_data.root_sq << 2) + (pct_pkg::SQ_W'(in_data.root) << 2)
                         + pct_pkg::SQ_W'(1);
      end else begin
         data_in.rem     = in_data.rem;
         data_in.root    = root_dbl;
         data_in.root_sq = in_data.root_sq << 2;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/core/perfect_cube_test.sv
// perfect cube test: chain of cube root digit cells
// req_ch carries one signed 32 bit value per word; rsp_ch returns one word per
// request with is_cube and negative_error. a negative value gives
// negative_error = 1 and is_cube = 0; zero counts as a cube.
// the value runs through a row of STEPS cells (11 at a 32 bit data width),
// each settling one bit of the integer cube root and keeping the remainder
// value - root^3; the value is a cube when that remainder ends at zero.
// a word moves through the register of every cell before showing on rsp_ch,
// and one word is taken every cycle while the receiver keeps up.
// every cell holds its own valid bit and ready is !valid || downstream ready,
// so a stalled receiver fills the chain from the output end first; empty
// cells keep taking words until all STEPS cells are full.
// the last cell is the output register and holds its word until taken.
// reset is synchronous and empties every cell; no word is lost or repeated.
`include "perfect_cube_test_defines.svh"

module perfect_cube_test (
   input  logic      clock,
   input  logic      reset,
   pct_req_if.sink   req_ch,
   pct_rsp_if.source rsp_ch
);

   logic [pct_pkg::STEPS:0]     link_valid;
   logic [pct_pkg::STEPS:0]     link_ready;
   pct_pkg::stage_type          link_data [pct_pkg::STEPS+1];
   logic [pct_pkg::EXT_W-1:0]   value_ext;

   assign value_ext = pct_pkg::EXT_W'($unsigned(req_ch.value));

   always_comb begin
      link_data[0].rem     = value_ext[pct_pkg::DATA_WIDTH-1:0];
      link_data[0].neg     = value_ext[pct_pkg::DATA_WIDTH-1];
      link_data[0].root    = '0;
      link_data[0].root_sq = '0;
   end

   assign link_valid[0] = req_ch.valid;
   assign req_ch.ready  = link_ready[0];

   for (genvar i = 0; i < pct_pkg::STEPS; i++) begin : g_cell
      pct_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (pct_pkg::SHIFT_W'(3 * (pct_pkg::STEPS - 1 - i))),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   assign rsp_ch.valid          = link_valid[pct_pkg::STEPS];
   assign link_ready[pct_pkg::STEPS] = rsp_ch.ready;
   assign rsp_ch.negative_error = link_data[pct_pkg::STEPS].neg;
   assign rsp_ch.is_cube        = !link_data[pct_pkg::STEPS].neg
                                && (link_data[pct_pkg::STEPS].rem == '0);

   // negative words never claim a cube
   `PCT_ASSERT_SAME(a_neg_not_cube, rsp_ch.valid && rsp_ch.negative_error, !rsp_ch.is_cube, "negative value reported as cube")

   // an accepted request lands in the first cell
   `PCT_ASSERT_NEXT(a_first_cell_fill, req_ch.valid && req_ch.ready, link_valid[1], "accepted word missing from first cell")

   // a taken response with nothing behind it leaves the output empty
   `PCT_ASSERT_NEXT(a_no_repeat, rsp_ch.valid && rsp_ch.ready && !link_valid[pct_pkg::STEPS-1], !rsp_ch.valid, "response word repeated")

endmodule

### dv/tb_top.sv
// testbench for the perfect cube test block: directed values, random phases, back-pressure
module tb_top;

   typedef struct packed {
      logic [31:0] value;
      logic        is_cube;
      logic        negative_error;
   } cube_verdict_type;

   logic clock;
   logic reset;

   pct_req_if req_ch ();
   pct_rsp_if rsp_ch ();

   perfect_cube_test uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cube_verdict_type pending_verdicts[$];
   int               err_count      = 0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               hold_cycles    = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 400000);
      $display("tb_top: done, errors");
      $finish;
   end

   // exact integer cube root, then root cubed against the value
   function automatic cube_verdict_type cube_verdict(input logic [31:0] value);
      logic [63:0]      v;
      logic [63:0]      x;
      logic [63:0]      y;
      logic [63:0]      b;
      int               s;
      cube_verdict_type res;
      v = {32'b0, value};
      if (pct_pkg::DATA_WIDTH < 64) begin
         v = v & ((64'd1 << pct_pkg::DATA_WIDTH) - 64'd1);
      end
      res.value          = value;
      res.negative_error = v[pct_pkg::DATA_WIDTH-1];
      res.is_cube        = 1'b0;
      if (!res.negative_error) begin
         x = v;
         y = 64'd0;
         s = ((pct_pkg::DATA_WIDTH - 1) / 3) * 3;
         if (s > 63) begin
            s = 63;
         end
         while (s >= 0) begin
            y = y << 1;
            b = 64'd3 * y * (y + 64'd1) + 64'd1;
            if ((x >> s) >= b) begin
               x = x - (b << s);
               y = y + 64'd1;
            end
            s = s - 3;
         end
         res.is_cube = (y * y * y == v);
      end
      return res;
   endfunction

   function automatic logic [31:0] random_value();
      int unsigned r;
      logic [31:0] v;
      r = $urandom_range(1290);
      case ($urandom_range(5))
         0: v = r * r * r;
         1: v = r * r * r + $urandom_range(2) - 1;
         2: v = $urandom_range(1000);
         3: v = {1'b1, 31'($urandom)};
         4: v = {1'b0, 31'($urandom)};
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // receiver: long hold-off first, otherwise random stalls
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response word is taken at the next rising edge
   always @(negedge clock) begin
      cube_verdict_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected word: is_cube %b negative_error %b",
                     $time, rsp_ch.is_cube, rsp_ch.negative_error);
            err_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_ch.is_cube !== want.is_cube) begin
               $display("%0t: value %h: is_cube expected %b, got %b",
                        $time, want.value, want.is_cube, rsp_ch.is_cube);
               err_count++;
            end
            if (rsp_ch.negative_error !== want.negative_error) begin
               $display("%0t: value %h: negative_error expected %b, got %b",
                        $time, want.value, want.negative_error, rsp_ch.negative_error);
               err_count++;
            end
         end
      end
   end

   task automatic set_idling(input int send_pct, input int recv_pct, input int hold);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      hold_cycles    = hold;
      @(posedge clock);
   endtask

   // called at a rising edge, returns at the edge where the word is taken
   task automatic send_value(input logic [31:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         req_ch.value <= $urandom;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      do @(negedge clock); while (req_ch.ready !== 1'b1);
      @(posedge clock);
      pending_verdicts = {pending_verdicts, cube_verdict(v)};
   endtask

   task automatic wait_for_verdicts();
      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (pct_pkg::STEPS + 4) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [31:0] values[$];
      values = '{32'd0, 32'd1, 32'd2, 32'd7, 32'd8, 32'd9, 32'd26, 32'd27, 32'd64,
                 32'd1331, 32'd999999, 32'd1000000, 32'd1000001,
                 32'd2146688999, 32'd2146689000, 32'd2146689001,
                 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_fff8,
                 32'h5555_5555, 32'haaaa_aaaa};
      set_idling(0, 0, 0);
      foreach (values[i]) send_value(values[i]);
      wait_for_verdicts();
   endtask

   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      set_idling(send_pct, recv_pct, 0);
      repeat (count) send_value(random_value());
      wait_for_verdicts();
   endtask

   // receiver holds off while the sender keeps offering, so the cell row fills
   task automatic test_backpressure();
      set_idling(0, 0, 80);
      repeat (40) send_value(random_value());
      wait_for_verdicts();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.value   = 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(85, 0, 0);
      test_random(85, 65, 0);
      test_random(85, 0, 65);
      test_random(85, 34, 34);
      test_backpressure();
      if (err_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule

### perfect_cube_test.f
+incdir+rtl/core
rtl/core/pct_pkg.sv
rtl/core/pct_req_if.sv
rtl/core/pct_rsp_if.sv
rtl/core/pct_cell.sv
rtl/core/perfect_cube_test.sv
dv/tb_top.sv
